FILE: design/wfpu_pkg.sv
`timescale 1ns / 1ps

package wfpu_pkg;

    // Default width of the decoded payload length and of the byte offset.
    localparam int LENGTH_WIDTH_DEF = 63;

    // Fixed result fields ahead of the two length-sized fields:
    // payload byte, FIN, opcode and mask flag.
    localparam int HDR_FIELDS_W = 14;

    // Seven-bit length codes that announce an extended length.
    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

    // Number of extended length bytes for each of those codes.
    localparam logic [3:0] EXT_BYTES_16 = 4'd2;
    localparam logic [3:0] EXT_BYTES_64 = 4'd8;

endpackage

FILE: design/websocket_frame_parse_unmask.sv
`timescale 1ns / 1ps

// WebSocket frame decoder with unmasking. Raw frame bytes enter on the slave
// stream at up to one byte per cycle. Header, extended length and masking key
// bytes are consumed without output; each payload byte is unmasked,
// registered and sent on the master stream, tagged with the frame's FIN
// bit, opcode, mask flag, length and its offset in the payload. A frame
// with a zero-length payload yields one result with tuser set and tlast set.
// The parser logic is combinational ahead of a single result register,
// and a one-entry skid stage keeps the input open for one more request
// while a result waits on the master side.

module websocket_frame_parse_unmask #(
    parameter int LENGTH_WIDTH = wfpu_pkg::LENGTH_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,

    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    // data_byte[7:0]
    input  logic [7:0] s_axis_tdata,

    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // From the lowest bit: payload_byte, fin_flag, frame_opcode, was_masked,
    // frame_length, byte_offset, zero fill to a whole byte.
    output logic [((wfpu_pkg::HDR_FIELDS_W + 2 * LENGTH_WIDTH + 7) / 8) * 8 - 1:0]
                 m_axis_tdata,
    // last_byte
    output logic m_axis_tlast,
    // empty_frame
    output logic m_axis_tuser
);

    localparam int FIELDS_W = wfpu_pkg::HDR_FIELDS_W + 2 * LENGTH_WIDTH;
    localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;
    localparam int RES_W    = FIELDS_W + 2;

    logic             w_accept;
    logic             w_res_valid;
    logic [RES_W-1:0] w_res;
    logic [RES_W-1:0] w_out;

    assign w_accept = s_axis_tvalid && s_axis_tready;

    wfpu_parse #(
        .LENGTH_WIDTH (LENGTH_WIDTH),
        .RES_W        (RES_W)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_accept),
        .i_byte      (s_axis_tdata),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    wfpu_skid #(
        .WIDTH (RES_W)
    ) u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_res_valid),
        .i_data  (w_res),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (w_out),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = TDATA_W'(w_out[FIELDS_W-1:0]);
    assign m_axis_tlast = w_out[FIELDS_W];
    assign m_axis_tuser = w_out[FIELDS_W+1];

endmodule

FILE: design/wfpu_parse.sv
`timescale 1ns / 1ps

module wfpu_parse #(
    parameter int LENGTH_WIDTH = wfpu_pkg::LENGTH_WIDTH_DEF,
    parameter int RES_W        = wfpu_pkg::HDR_FIELDS_W + 2 * LENGTH_WIDTH + 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_byte,
    output logic             o_res_valid,
    // From the lowest bit: payload_byte, fin_flag, frame_opcode, was_masked,
    // frame_length, byte_offset, last_byte, empty_frame.
    output logic [RES_W-1:0] o_res
);

    typedef enum logic [2:0] {
        PH_HDR1,
        PH_HDR2,
        PH_EXT,
        PH_KEY,
        PH_DATA
    } t_phase;

    t_phase                  r_phase, n_phase;
    logic                    r_fin, n_fin;
    logic [3:0]              r_opcode, n_opcode;
    logic                    r_mask, n_mask;
    logic [LENGTH_WIDTH-1:0] r_len, n_len;
    logic [3:0]              r_ext, n_ext;
    logic [7:0]              r_key [4];
    logic [1:0]              r_key_idx, n_key_idx;
    logic [LENGTH_WIDTH-1:0] r_count, n_count;

    logic                    w_key_wr;
    logic [LENGTH_WIDTH-1:0] w_count_inc;
    logic [7:0]              w_key_byte;
    logic                    w_res;
    logic [7:0]              w_payload;
    logic [LENGTH_WIDTH-1:0] w_offset;
    logic                    w_last;
    logic                    w_empty;

    assign w_count_inc = r_count + LENGTH_WIDTH'(1);
    assign w_key_byte  = r_mask ? r_key[r_count[1:0]] : 8'h00;

    always_comb begin
        n_phase   = r_phase;
        n_fin     = r_fin;
        n_opcode  = r_opcode;
        n_mask    = r_mask;
        n_len     = r_len;
        n_ext     = r_ext;
        n_key_idx = r_key_idx;
        n_count   = r_count;
        w_key_wr  = 1'b0;
        w_res     = 1'b0;
        w_payload = 8'h00;
        w_offset  = '0;
        w_last    = 1'b0;
        w_empty   = 1'b0;

        // A header is complete once the length and, if present, the key
        // are in. A zero length then yields the single empty result.
        case (r_phase)
            PH_HDR1: begin
                n_fin    = i_byte[7];
                n_opcode = i_byte[3:0];
                n_phase  = PH_HDR2;
            end
            PH_HDR2: begin
                n_mask = i_byte[7];
                if (i_byte[6:0] == wfpu_pkg::LEN_CODE_EXT16) begin
                    n_len   = '0;
                    n_ext   = wfpu_pkg::EXT_BYTES_16;
                    n_phase = PH_EXT;
                end else if (i_byte[6:0] == wfpu_pkg::LEN_CODE_EXT64) begin
                    n_len   = '0;
                    n_ext   = wfpu_pkg::EXT_BYTES_64;
                    n_phase = PH_EXT;
                end else begin
                    n_len = LENGTH_WIDTH'(i_byte[6:0]);
                    if (i_byte[7]) begin
                        n_key_idx = 2'd0;
                        n_phase   = PH_KEY;
                    end else if (i_byte[6:0] == 7'd0) begin
                        w_res   = 1'b1;
                        w_last  = 1'b1;
                        w_empty = 1'b1;
                        n_phase = PH_HDR1;
                    end else begin
                        n_count = '0;
                        n_phase = PH_DATA;
                    end
                end
            end
            PH_EXT: begin
                n_len = {r_len[LENGTH_WIDTH-9:0], i_byte};
                n_ext = r_ext - 4'((r_ext != 4'd0) ? 1 : 0);
                if (n_ext == 4'd0) begin
                    if (r_mask) begin
                        n_key_idx = 2'd0;
                        n_phase   = PH_KEY;
                    end else if (n_len == '0) begin
                        w_res   = 1'b1;
                        w_last  = 1'b1;
                        w_empty = 1'b1;
                        n_phase = PH_HDR1;
                    end else begin
                        n_count = '0;
                        n_phase = PH_DATA;
                    end
                end
            end
            PH_KEY: begin
                w_key_wr  = 1'b1;
                n_key_idx = r_key_idx + 2'd1;
                if (r_key_idx == 2'd3) begin
                    if (r_len == '0) begin
                        w_res   = 1'b1;
                        w_last  = 1'b1;
                        w_empty = 1'b1;
                        n_phase = PH_HDR1;
                    end else begin
                        n_count = '0;
                        n_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                w_res     = 1'b1;
                w_payload = i_byte ^ w_key_byte;
                w_offset  = r_count;
                w_last    = (w_count_inc == r_len);
                n_count   = w_count_inc;
                if (w_last) begin
                    n_phase = PH_HDR1;
                end
            end
            default: begin
                n_phase = PH_HDR1;
            end
        endcase
    end

    assign o_res_valid = i_valid && w_res;
    assign o_res = {w_empty, w_last, w_offset, n_len, n_mask, n_opcode, n_fin, w_payload};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HDR1;
            r_fin     <= 1'b0;
            r_opcode  <= 4'd0;
            r_mask    <= 1'b0;
            r_len     <= '0;
            r_ext     <= 4'd0;
            r_key     <= '{default: 8'h00};
            r_key_idx <= 2'd0;
            r_count   <= '0;
        end else if (i_valid) begin
            r_phase   <= n_phase;
            r_fin     <= n_fin;
            r_opcode  <= n_opcode;
            r_mask    <= n_mask;
            r_len     <= n_len;
            r_ext     <= n_ext;
            r_key_idx <= n_key_idx;
            r_count   <= n_count;
            if (w_key_wr) begin
                r_key[r_key_idx] <= i_byte;
            end
        end
    end

endmodule

FILE: design/wfpu_skid.sv
`timescale 1ns / 1ps

module wfpu_skid #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_ready
);

    logic             r_out_valid;
    logic [WIDTH-1:0] r_out;
    logic             r_skid_valid;
    logic [WIDTH-1:0] r_skid;
    logic             w_push;

    // The upstream side only stalls once the skid entry is occupied.
    assign o_ready = !r_skid_valid;
    assign w_push  = i_valid && !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_push;
                r_out       <= i_data;
            end
        end else if (w_push) begin
            r_skid_valid <= 1'b1;
            r_skid       <= i_data;
        end
    end

endmodule

FILE: tb/wfpu_frame_checker.sv
`timescale 1ns / 1ps

// Watches both streams of the frame decoder, decodes the accepted input bytes
// on its own and compares every result request against the oldest decoded one.
module wfpu_frame_checker #(
    parameter int LW = wfpu_pkg::LENGTH_WIDTH_DEF,
    parameter int TDATA_W = ((wfpu_pkg::HDR_FIELDS_W + 2 * LW + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [7:0]         i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [TDATA_W-1:0] i_out_data,
    input  logic               i_out_last,
    input  logic               i_out_user,
    output int                 o_fail_count,
    output int                 o_pending
);
    import wfpu_pkg::*;

    typedef enum logic [2:0] {
        ST_HDR1,
        ST_HDR2,
        ST_EXT_LEN,
        ST_KEY,
        ST_PAYLOAD
    } parse_state_e;

    typedef struct {
        logic [7:0]    pbyte;
        logic          fin;
        logic [3:0]    opcode;
        logic          masked;
        logic [LW-1:0] length;
        logic [LW-1:0] offset;
        logic          last;
        logic          empty;
    } frame_byte_t;

    parse_state_e  state;
    logic          hdr_fin;
    logic [3:0]    hdr_opcode;
    logic          hdr_masked;
    logic [LW-1:0] frame_len;
    logic [3:0]    ext_left;
    logic [7:0]    mask_key [4];
    logic [1:0]    key_idx;
    logic [LW-1:0] pay_pos;

    frame_byte_t   unmasked_q [$];

    task automatic push_result(input logic [7:0] pbyte, input logic [LW-1:0] offset,
                               input logic last, input logic empty);
        frame_byte_t r;
        r.pbyte  = pbyte;
        r.fin    = hdr_fin;
        r.opcode = hdr_opcode;
        r.masked = hdr_masked;
        r.length = frame_len;
        r.offset = offset;
        r.last   = last;
        r.empty  = empty;
        unmasked_q.push_back(r);
    endtask

    // Length and key are known: either the frame is empty and ends here,
    // or its payload follows.
    task automatic header_complete();
        if (frame_len == '0) begin
            push_result(8'd0, '0, 1'b1, 1'b1);
            state = ST_HDR1;
        end else begin
            pay_pos = '0;
            state = ST_PAYLOAD;
        end
    endtask

    task automatic length_complete();
        if (hdr_masked) begin
            key_idx = 2'd0;
            state = ST_KEY;
        end else begin
            header_complete();
        end
    endtask

    task automatic decode_byte(input logic [7:0] b);
        logic [6:0]    code;
        logic [7:0]    k;
        logic [LW-1:0] next_pos;
        case (state)
            ST_HDR1: begin
                hdr_fin = b[7];
                hdr_opcode = b[3:0];
                state = ST_HDR2;
            end
            ST_HDR2: begin
                hdr_masked = b[7];
                code = b[6:0];
                frame_len = '0;
                if (code == LEN_CODE_EXT16) begin
                    ext_left = EXT_BYTES_16;
                    state = ST_EXT_LEN;
                end else if (code == LEN_CODE_EXT64) begin
                    ext_left = EXT_BYTES_64;
                    state = ST_EXT_LEN;
                end else begin
                    frame_len = LW'(code);
                    length_complete();
                end
            end
            ST_EXT_LEN: begin
                // Bits shifted past the top of the length are lost.
                frame_len = {frame_len[LW-9:0], b};
                if (ext_left != 4'd0) ext_left = ext_left - 4'd1;
                if (ext_left == 4'd0) length_complete();
            end
            ST_KEY: begin
                mask_key[key_idx] = b;
                key_idx = key_idx + 2'd1;
                if (key_idx == 2'd0) header_complete();
            end
            ST_PAYLOAD: begin
                k = hdr_masked ? mask_key[pay_pos[1:0]] : 8'd0;
                next_pos = pay_pos + 1'b1;
                push_result(b ^ k, pay_pos, next_pos == frame_len, 1'b0);
                pay_pos = next_pos;
                if (next_pos == frame_len) state = ST_HDR1;
            end
            default: state = ST_HDR1;
        endcase
    endtask

    task automatic check_field(input string name, input logic [LW-1:0] exp_v,
                               input logic [LW-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        frame_byte_t e;
        if (!i_rst_n) begin
            state = ST_HDR1;
            hdr_fin = 1'b0;
            hdr_opcode = 4'd0;
            hdr_masked = 1'b0;
            frame_len = '0;
            ext_left = 4'd0;
            for (int i = 0; i < 4; i++) mask_key[i] = 8'd0;
            key_idx = 2'd0;
            pay_pos = '0;
            unmasked_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) decode_byte(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (unmasked_q.size() == 0) begin
                    $display("%0t: unexpected result request, expected none, got %0h",
                             $time, i_out_data);
                    o_fail_count++;
                end else begin
                    e = unmasked_q.pop_front();
                    check_field("payload_byte", LW'(e.pbyte), LW'(i_out_data[7:0]));
                    check_field("fin_flag", LW'(e.fin), LW'(i_out_data[8]));
                    check_field("frame_opcode", LW'(e.opcode), LW'(i_out_data[12:9]));
                    check_field("was_masked", LW'(e.masked), LW'(i_out_data[13]));
                    check_field("frame_length", e.length,
                                i_out_data[HDR_FIELDS_W +: LW]);
                    check_field("byte_offset", e.offset,
                                i_out_data[HDR_FIELDS_W + LW +: LW]);
                    check_field("last_byte", LW'(e.last), LW'(i_out_last));
                    check_field("empty_frame", LW'(e.empty), LW'(i_out_user));
                end
            end
        end
        o_pending = unmasked_q.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import wfpu_pkg::*;

    localparam int LW = LENGTH_WIDTH_DEF;
    localparam int TDATA_W = ((HDR_FIELDS_W + 2 * LW + 7) / 8) * 8;
    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_CYCLES = 200;

    typedef enum logic [1:0] {
        LEN_SHORT,
        LEN_EXT16,
        LEN_EXT64
    } len_enc_e;

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic               m_axis_tlast;
    logic               m_axis_tuser;

    int                 fail_count;
    int                 pending;
    int                 n_in_accepted;
    int                 idle_cycles;
    logic [7:0]         stream_bytes [$];

    websocket_frame_parse_unmask #(.LENGTH_WIDTH(LW)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    wfpu_frame_checker #(.LW(LW), .TDATA_W(TDATA_W)) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_last   (m_axis_tlast),
        .i_out_user   (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Queues one frame: header, length in the chosen encoding, a random key
    // when masked, and n_payload random payload bytes.
    task automatic add_frame(input logic [7:0] hdr0, input logic masked, input len_enc_e enc,
                             input logic [63:0] len_field, input int n_payload);
        stream_bytes.push_back(hdr0);
        case (enc)
            LEN_SHORT: begin
                stream_bytes.push_back({masked, len_field[6:0]});
            end
            LEN_EXT16: begin
                stream_bytes.push_back({masked, LEN_CODE_EXT16});
                stream_bytes.push_back(len_field[15:8]);
                stream_bytes.push_back(len_field[7:0]);
            end
            default: begin
                stream_bytes.push_back({masked, LEN_CODE_EXT64});
                for (int i = 7; i >= 0; i--) stream_bytes.push_back(len_field[8*i +: 8]);
            end
        endcase
        if (masked) repeat (4) stream_bytes.push_back(8'($urandom_range(0, 255)));
        repeat (n_payload) stream_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            n_in_accepted <= 0;
            idle_cycles <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) n_in_accepted <= n_in_accepted + 1;
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Result side: stall modes change at random, and once the
    // receiver holds off long enough for the decoder to back up.
    initial begin
        int  mode;
        int  mode_left;
        logic hold_done;
        m_axis_tready = 1'b0;
        mode = 0;
        mode_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && n_in_accepted >= 150) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(8, 64);
            end
            mode_left--;
            case (mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    initial begin
        int          r;
        int          n;
        int          gap;
        int          burst_left;
        logic [63:0] len;

        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'd0;

        // Directed frames: empty unmasked frame with reserved bits set,
        // empty masked frame whose 64-bit length has only the dropped top bit,
        // empty frame with a zero 16-bit length, short masked frame.
        add_frame(8'h70, 1'b0, LEN_SHORT, 64'd0, 0);
        add_frame(8'hFF, 1'b1, LEN_EXT64, 64'h8000_0000_0000_0000, 0);
        add_frame(8'h01, 1'b0, LEN_EXT16, 64'd0, 0);
        add_frame(8'h82, 1'b1, LEN_SHORT, 64'd3, 3);

        while (stream_bytes.size() < 700) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                n = $urandom_range(0, 15);
                add_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), LEN_SHORT,
                          64'(n), n);
            end else if (r < 70) begin
                n = (r < 67) ? $urandom_range(16, 40) : $urandom_range(100, 125);
                add_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), LEN_SHORT,
                          64'(n), n);
            end else if (r < 82) begin
                // Non-minimal 16-bit lengths, now and then a longer frame.
                n = (r < 80) ? $urandom_range(0, 40) : $urandom_range(126, 300);
                add_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), LEN_EXT16,
                          64'(n), n);
            end else if (r < 94) begin
                n = $urandom_range(0, 24);
                len = {1'($urandom_range(0, 1)), 47'd0, 16'(n)};
                add_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), LEN_EXT64,
                          len, n);
            end else begin
                // Payload that looks like a long-length header must not
                // resynchronize the parser.
                add_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), LEN_SHORT,
                          64'd12, 0);
                stream_bytes.push_back(8'h81);
                stream_bytes.push_back({1'b1, LEN_CODE_EXT64});
                repeat (10) stream_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end

        // A frame with a huge length that the stream breaks off in the middle.
        len = {$urandom, $urandom} | 64'h7000_0000_0000_0000;
        add_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), LEN_EXT64, len, 6);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        burst_left = 0;
        while (stream_bytes.size() > 0) begin
            if (burst_left == 0) begin
                gap = $urandom_range(0, 6);
                if (gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
                burst_left = $urandom_range(1, 40);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= stream_bytes.pop_front();
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
            @(negedge i_clk);
            burst_left--;
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
